FILE: hdl/lzcd_pkg.sv
// Shared types and constants for the LZ control-bit decompressor.
// Used by the front parser, the command queue, the back end and the top level.
`default_nettype none
package lzcd_pkg;

   localparam int unsigned DIST_W = 14;   // copy distance 1..8192
   localparam int unsigned LEN_W  = 9;    // copy length 1..256
   localparam int unsigned DATA_W = 64;   // packed result word
   localparam int unsigned CNT_W  = 4;    // byte count of one result

   // parser phase, one per control bit or data byte position
   typedef enum logic [3:0] {
      PH_CMD       = 4'd0,
      PH_KIND      = 4'd1,
      PH_SHORT_HI  = 4'd2,
      PH_SHORT_LO  = 4'd3,
      PH_LITERAL   = 4'd4,
      PH_SHORT_OFS = 4'd5,
      PH_LONG_LO   = 4'd6,
      PH_LONG_HI   = 4'd7,
      PH_LONG_LEN  = 4'd8
   } phase_type;

   typedef enum logic [1:0] {
      CMD_LIT  = 2'd0,
      CMD_COPY = 2'd1,
      CMD_END  = 2'd2
   } cmd_kind_type;

   // one decoded command handed from front to back
   typedef struct packed {
      cmd_kind_type         kind;
      logic [7:0]           lit;
      logic [DIST_W-1:0]    distance;
      logic [LEN_W-1:0]     len;
   } cmd_type;

   typedef enum logic [1:0] {
      B_IDLE  = 2'd0,
      B_READ  = 2'd1,
      B_WRITE = 2'd2,
      B_END   = 2'd3
   } back_state_type;

endpackage
`default_nettype wire

FILE: hdl/lzcd_front.sv
// Front parser: consumes compressed bytes, walks the control bits and emits commands.
// Depends on lzcd_pkg.
`default_nettype none
module lzcd_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [7:0]       req_in_byte,
   input  wire logic             q_full,
   output logic                  q_push,
   output lzcd_pkg::cmd_type     q_cmd
);
   import lzcd_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [7:0]        ctl_ff, ctl_in;
   logic [3:0]        bits_ff, bits_in;
   logic [1:0]        slen_ff, slen_in;
   logic [7:0]        lo_ff, lo_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic              bit_phase, byte_phase, take;
   logic [15:0]       word;

   always_comb begin
      bit_phase  = (phase_ff == PH_CMD) || (phase_ff == PH_KIND) ||
                   (phase_ff == PH_SHORT_HI) || (phase_ff == PH_SHORT_LO);
      byte_phase = !bit_phase || (bits_ff == 4'd0);
      req_stall  = !byte_phase || q_full;
      take       = req_valid && !req_stall;
      word       = {req_in_byte, lo_ff};
   end

   // next parse state and command formation
   always_comb begin
      phase_in = phase_ff;
      ctl_in   = ctl_ff;
      bits_in  = bits_ff;
      slen_in  = slen_ff;
      lo_in    = lo_ff;
      dist_in  = dist_ff;
      q_push   = 1'b0;
      q_cmd    = '{kind: CMD_LIT, lit: req_in_byte, distance: dist_ff, len: LEN_W'(1)};
      if (bit_phase && bits_ff != 4'd0) begin
         ctl_in  = {1'b0, ctl_ff[7:1]};
         bits_in = bits_ff - 4'd1;
         case (phase_ff)
            PH_CMD:      phase_in = ctl_ff[0] ? PH_LITERAL : PH_KIND;
            PH_KIND:     phase_in = ctl_ff[0] ? PH_LONG_LO : PH_SHORT_HI;
            PH_SHORT_HI: begin
               slen_in  = {ctl_ff[0], 1'b0};
               phase_in = PH_SHORT_LO;
            end
            default: begin
               slen_in  = {slen_ff[1], ctl_ff[0]};
               phase_in = PH_SHORT_OFS;
            end
         endcase
      end else if (take) begin
         case (phase_ff)
            PH_LITERAL: begin
               q_push   = 1'b1;
               phase_in = PH_CMD;
            end
            PH_SHORT_OFS: begin
               q_push         = 1'b1;
               q_cmd.kind     = CMD_COPY;
               q_cmd.distance = DIST_W'(9'd256 - {1'b0, req_in_byte});
               q_cmd.len      = LEN_W'({1'b0, slen_ff} + 3'd2);
               phase_in       = PH_CMD;
            end
            PH_LONG_LO: begin
               lo_in    = req_in_byte;
               phase_in = PH_LONG_HI;
            end
            PH_LONG_HI: begin
               if (word == 16'd0) begin
                  q_push     = 1'b1;
                  q_cmd.kind = CMD_END;
                  ctl_in     = 8'd0;
                  bits_in    = 4'd0;
                  phase_in   = PH_CMD;
               end else begin
                  dist_in = DIST_W'(14'd8192 - {1'b0, word[15:3]});
                  if (lo_ff[2:0] != 3'd0) begin
                     q_push         = 1'b1;
                     q_cmd.kind     = CMD_COPY;
                     q_cmd.distance = dist_in;
                     q_cmd.len      = LEN_W'({1'b0, lo_ff[2:0]} + 4'd2);
                     phase_in       = PH_CMD;
                  end else begin
                     phase_in = PH_LONG_LEN;
                  end
               end
            end
            PH_LONG_LEN: begin
               q_push     = 1'b1;
               q_cmd.kind = CMD_COPY;
               q_cmd.len  = LEN_W'({1'b0, req_in_byte} + 9'd1);
               phase_in   = PH_CMD;
            end
            default: begin
               // bit phase with no bits left: this is a control byte
               ctl_in  = req_in_byte;
               bits_in = 4'd8;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_CMD;
         ctl_ff   <= 8'd0;
         bits_ff  <= 4'd0;
         slen_ff  <= 2'd0;
         lo_ff    <= 8'd0;
         dist_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         ctl_ff   <= ctl_in;
         bits_ff  <= bits_in;
         slen_ff  <= slen_in;
         lo_ff    <= lo_in;
         dist_ff  <= dist_in;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/lzcd_cmd_fifo.sv
// Two-entry command queue between the front parser and the back end.
// Depends on lzcd_pkg.
`default_nettype none
module lzcd_cmd_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire lzcd_pkg::cmd_type push_cmd,
   input  wire logic              pop,
   output lzcd_pkg::cmd_type      head,
   output logic                   full,
   output logic                   empty
);
   import lzcd_pkg::*;

   cmd_type     slot_ff [2];
   logic        wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]  cnt_ff, cnt_in;

   always_comb begin
      full  = (cnt_ff == 2'd2);
      empty = (cnt_ff == 2'd0);
      head  = slot_ff[rd_ff];
      wr_in = push ? !wr_ff : wr_ff;
      rd_in = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/lzcd_back.sv
// Back end: runs literal, copy and end commands against the history memory
// and packs the produced bytes into result words. Depends on lzcd_pkg.
`default_nettype none
module lzcd_back #(
   parameter int unsigned HISTORY_DEPTH    = 8192,
   parameter int unsigned BYTES_PER_RESULT = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lzcd_pkg::cmd_type             q_head,
   input  wire logic                          q_empty,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [lzcd_pkg::DATA_W-1:0]        rsp_out_data,
   output logic [lzcd_pkg::CNT_W-1:0]         rsp_out_count,
   output logic                               rsp_last_of_run,
   output logic                               rsp_stream_end
);
   import lzcd_pkg::*;

   localparam int unsigned AW = $clog2(HISTORY_DEPTH);
   localparam int unsigned PW = AW + 1;

   logic [7:0]        mem [HISTORY_DEPTH];

   back_state_type    st_ff, st_in;
   logic [AW-1:0]     wp_ff, wp_in, rp_ff, rp_in;
   logic              wrapped_ff, wrapped_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic              lit_ff, lit_in;
   logic [7:0]        lbyte_ff, lbyte_in;
   logic [7:0]        rdata_ff;
   logic              zero_ff;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0]  accn_ff, accn_in;
   logic              ov_ff, ov_in;
   logic [DATA_W-1:0] od_ff, od_in;
   logic [CNT_W-1:0]  oc_ff, oc_in;
   logic              ol_ff, ol_in, oe_ff, oe_in;

   logic              slot_free, need_flush, go, wr_en;
   logic [7:0]        cur;
   logic [DATA_W-1:0] merged;
   logic [PW-1:0]     wp_ext, dist_ext;

   always_comb begin
      slot_free  = !ov_ff || !rsp_stall;
      cur        = lit_ff ? lbyte_ff : (zero_ff ? 8'd0 : rdata_ff);
      merged     = acc_ff | ({{(DATA_W-8){1'b0}}, cur} << {accn_ff, 3'b000});
      need_flush = (accn_ff + CNT_W'(1) == CNT_W'(BYTES_PER_RESULT)) ||
                   (rem_ff == LEN_W'(1));
      go         = !need_flush || slot_free;
      wp_ext     = {1'b0, wp_ff};
      dist_ext   = PW'(q_head.distance);
   end

   // command sequencer and result packing
   always_comb begin
      st_in      = st_ff;
      wp_in      = wp_ff;
      rp_in      = rp_ff;
      wrapped_in = wrapped_ff;
      rem_in     = rem_ff;
      lit_in     = lit_ff;
      lbyte_in   = lbyte_ff;
      acc_in     = acc_ff;
      accn_in    = accn_ff;
      q_pop      = 1'b0;
      wr_en      = 1'b0;
      ov_in      = ov_ff && rsp_stall;
      od_in      = od_ff;
      oc_in      = oc_ff;
      ol_in      = ol_ff;
      oe_in      = oe_ff;
      case (st_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               lbyte_in = q_head.lit;
               rem_in   = q_head.len;
               case (q_head.kind)
                  CMD_LIT: begin
                     lit_in = 1'b1;
                     rem_in = LEN_W'(1);
                     st_in  = B_WRITE;
                  end
                  CMD_COPY: begin
                     lit_in = 1'b0;
                     if (wp_ext >= dist_ext) begin
                        rp_in = AW'(wp_ext - dist_ext);
                     end else begin
                        rp_in = AW'(wp_ext + PW'(HISTORY_DEPTH) - dist_ext);
                     end
                     st_in = B_READ;
                  end
                  default: st_in = B_END;
               endcase
            end
         end
         B_READ: begin
            rp_in = (rp_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : rp_ff + AW'(1);
            st_in = B_WRITE;
         end
         B_WRITE: begin
            if (go) begin
               wr_en   = 1'b1;
               wp_in   = (wp_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_ff + AW'(1);
               if (wp_ff == AW'(HISTORY_DEPTH - 1)) begin
                  wrapped_in = 1'b1;
               end
               rem_in  = rem_ff - LEN_W'(1);
               acc_in  = merged;
               accn_in = accn_ff + CNT_W'(1);
               if (need_flush) begin
                  ov_in   = 1'b1;
                  od_in   = merged;
                  oc_in   = accn_ff + CNT_W'(1);
                  ol_in   = (rem_ff == LEN_W'(1));
                  oe_in   = 1'b0;
                  acc_in  = '0;
                  accn_in = '0;
               end
               st_in = (rem_ff == LEN_W'(1)) ? B_IDLE : B_READ;
            end
         end
         default: begin
            if (slot_free) begin
               ov_in = 1'b1;
               od_in = '0;
               oc_in = '0;
               ol_in = 1'b1;
               oe_in = 1'b1;
               st_in = B_IDLE;
            end
         end
      endcase
   end

   // history write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wp_ff] <= cur;
      end
   end

   // history read port; entries beyond the fill count read as zero
   always_ff @(posedge clock) begin
      if (st_ff == B_READ) begin
         rdata_ff <= mem[rp_ff];
         zero_ff  <= !(wrapped_ff || (rp_ff < wp_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= B_IDLE;
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
         accn_ff    <= '0;
         acc_ff     <= '0;
         ov_ff      <= 1'b0;
      end else begin
         st_ff      <= st_in;
         wp_ff      <= wp_in;
         wrapped_ff <= wrapped_in;
         accn_ff    <= accn_in;
         acc_ff     <= acc_in;
         ov_ff      <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      rp_ff    <= rp_in;
      rem_ff   <= rem_in;
      lit_ff   <= lit_in;
      lbyte_ff <= lbyte_in;
      od_ff    <= od_in;
      oc_ff    <= oc_in;
      ol_ff    <= ol_in;
      oe_ff    <= oe_in;
   end

   assign rsp_valid       = ov_ff;
   assign rsp_out_data    = od_ff;
   assign rsp_out_count   = oc_ff;
   assign rsp_last_of_run = ol_ff;
   assign rsp_stream_end  = oe_ff;

endmodule
`default_nettype wire

FILE: hdl/lz_control_bit_decompressor.sv
// LZ control-bit decompressor, top level.
// Compressed bytes enter on the req_ channel (req_valid / req_stall / req_in_byte).
// Decoded bytes leave on the rsp_ channel as packed words: rsp_out_data holds up to
// BYTES_PER_RESULT bytes, earliest in bits 7:0, rsp_out_count says how many.
// rsp_last_of_run marks the final result word of one decoded command;
// rsp_stream_end marks the end-of-stream word (count 0, data 0).
// A front parser takes one byte per cycle when it needs one and the queue is not
// full, and walks the control bits one by one without taking a byte; decoded
// commands pass through a two-entry queue to the back end. For each byte of a
// copy the back end does a registered history read, then a write and pack; a
// literal is written and packed straight after the queue pop, the end marker
// emits its word after the pop, and a write waits while its word cannot be output.
// Reset clears parser, queue and output register; the 8192-entry history needs no
// clearing pass, a fill count makes unwritten entries read as zero.
// When the receiver stalls, the output word holds; the back end then waits on the
// next word it must hand out, the queue fills and req_stall rises.
`default_nettype none
module lz_control_bit_decompressor #(
   parameter int unsigned HISTORY_DEPTH    = 8192,
   parameter int unsigned BYTES_PER_RESULT = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_out_data,
   output logic [3:0]       rsp_out_count,
   output logic             rsp_last_of_run,
   output logic             rsp_stream_end
);
   import lzcd_pkg::*;

   logic    q_full, q_empty, q_push, q_pop;
   cmd_type q_cmd, q_head;

   lzcd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_cmd       (q_cmd)
   );

   lzcd_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .full     (q_full),
      .empty    (q_empty)
   );

   lzcd_back #(
      .HISTORY_DEPTH    (HISTORY_DEPTH),
      .BYTES_PER_RESULT (BYTES_PER_RESULT)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_head          (q_head),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_data    (rsp_out_data),
      .rsp_out_count   (rsp_out_count),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_stream_end  (rsp_stream_end)
   );

`ifndef SYNTH
   // end marker carries no bytes and closes its run
   a_end_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_end |-> rsp_out_count == 4'd0 && rsp_last_of_run)
      else $error("end marker word malformed");

   // data words carry between one and BYTES_PER_RESULT bytes
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stream_end |->
         rsp_out_count != 4'd0 && rsp_out_count <= 4'(BYTES_PER_RESULT))
      else $error("data word byte count out of range");

   // the parser never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push || q_pop)
      else $error("command queue overflow");
`endif

endmodule
`default_nettype wire
